@@ hdl/agt_pkg.sv @@
// Types, codes and sizes shared by the adjacency-matrix graph traversal block.
package agt_pkg;

  localparam int VERTEX_LIMIT = 16;
  localparam int VIDX_W = 4;
  localparam int PTR_W = 5;
  localparam int COUNT_W = 5;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_EDGE = 2'd1;
  localparam logic [1:0] OP_BFS = 2'd2;
  localparam logic [1:0] OP_DFS = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [VIDX_W-1:0] vertex_a;
    logic [VIDX_W-1:0] vertex_b;
    logic [7:0]        weight;
  } agt_in_t;

  typedef struct packed {
    logic [VIDX_W-1:0] visited_vertex;
    logic              last_of_walk;
    logic              bad_start;
  } agt_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERR,
    ST_POP,
    ST_SCAN
  } agt_state_t;

  typedef struct packed {
    logic clear_rows;
    logic set_edge;
    logic start_walk;
    logic pop;
    logic push;
    logic emit_bad;
    logic emit_final;
  } agt_ctrl_t;

  typedef struct packed {
    logic start_bad;
    logic pend_empty;
    logic cand_any;
    logic have_prev;
    logic out_free;
  } agt_stat_t;

endpackage

@@ hdl/agt_ctrl.sv @@
// Controller state machine: sequences clear, edge update and the traversal steps.
module agt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_cmd,
  input  agt_pkg::agt_stat_t   stat,
  output agt_pkg::agt_ctrl_t   ctrl,
  output logic                 in_stall
);

  agt_pkg::agt_state_t state;
  agt_pkg::agt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= agt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    in_stall = (state != agt_pkg::ST_IDLE);
    unique case (state)
      agt_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd) inside
            agt_pkg::OP_CLEAR: ctrl.clear_rows = 1'b1;
            agt_pkg::OP_EDGE: ctrl.set_edge = 1'b1;
            agt_pkg::OP_BFS, agt_pkg::OP_DFS: begin
              if (stat.start_bad) begin
                state_next = agt_pkg::ST_ERR;
              end else begin
                ctrl.start_walk = 1'b1;
                state_next = agt_pkg::ST_POP;
              end
            end
            default: state_next = agt_pkg::ST_IDLE;
          endcase
        end
      end
      agt_pkg::ST_ERR: begin
        if (stat.out_free) begin
          ctrl.emit_bad = 1'b1;
          state_next = agt_pkg::ST_IDLE;
        end
      end
      agt_pkg::ST_POP: begin
        if (stat.pend_empty) begin
          if (stat.out_free) begin
            ctrl.emit_final = 1'b1;
            state_next = agt_pkg::ST_IDLE;
          end
        end else if (!stat.have_prev || stat.out_free) begin
          ctrl.pop = 1'b1;
          state_next = agt_pkg::ST_SCAN;
        end
      end
      agt_pkg::ST_SCAN: begin
        if (stat.cand_any) begin
          ctrl.push = 1'b1;
        end else begin
          state_next = agt_pkg::ST_POP;
        end
      end
      default: state_next = agt_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hdl/agt_dp.sv @@
// Datapath: adjacency rows, visited marks, pending store and the result register.
module agt_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  agt_pkg::agt_in_t              in_data,
  input  agt_pkg::agt_ctrl_t            ctrl,
  output agt_pkg::agt_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output agt_pkg::agt_out_t             out_data,
  input  logic                          cfg_write_en,
  input  logic [agt_pkg::COUNT_W-1:0]   cfg_write_data
);

  logic [agt_pkg::VERTEX_LIMIT-1:0] rows [agt_pkg::VERTEX_LIMIT];
  logic [agt_pkg::VERTEX_LIMIT-1:0] visited;
  logic [agt_pkg::VIDX_W-1:0]       pending [agt_pkg::VERTEX_LIMIT];
  logic [agt_pkg::PTR_W-1:0]        head;
  logic [agt_pkg::PTR_W-1:0]        tail;
  logic                             depth_first;
  logic                             have_prev;
  logic [agt_pkg::VIDX_W-1:0]       cur;
  logic [agt_pkg::COUNT_W-1:0]      vertex_count;

  logic [agt_pkg::COUNT_W-1:0]      n_eff;
  logic [agt_pkg::VERTEX_LIMIT-1:0] col_mask;
  logic [agt_pkg::VERTEX_LIMIT-1:0] cand;
  logic [agt_pkg::VERTEX_LIMIT-1:0] low_bit;
  logic [agt_pkg::VIDX_W-1:0]       low_idx;
  logic [agt_pkg::PTR_W-1:0]        pop_ptr;
  logic [agt_pkg::VIDX_W-1:0]       pop_vertex;
  logic                             edge_ok;
  logic                             out_free;

  assign n_eff = (vertex_count > agt_pkg::COUNT_W'(agt_pkg::VERTEX_LIMIT)) ?
                 agt_pkg::COUNT_W'(agt_pkg::VERTEX_LIMIT) : vertex_count;

  always_comb begin
    for (int i = 0; i < agt_pkg::VERTEX_LIMIT; i++) begin
      col_mask[i] = (agt_pkg::COUNT_W'(i) < n_eff);
    end
  end

  assign edge_ok = ({1'b0, in_data.vertex_a} < n_eff) && ({1'b0, in_data.vertex_b} < n_eff);

  assign cand = rows[cur] & ~visited & col_mask;
  assign low_bit = cand & (~cand + agt_pkg::VERTEX_LIMIT'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < agt_pkg::VERTEX_LIMIT; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | agt_pkg::VIDX_W'(i);
      end
    end
  end

  assign pop_ptr = depth_first ? (tail - agt_pkg::PTR_W'(1)) : head;
  assign pop_vertex = pending[pop_ptr[agt_pkg::VIDX_W-1:0]];
  assign out_free = !out_valid || !out_stall;

  assign stat.start_bad = ({1'b0, in_data.vertex_a} >= n_eff);
  assign stat.pend_empty = (head >= tail);
  assign stat.cand_any = (cand != '0);
  assign stat.have_prev = have_prev;
  assign stat.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= agt_pkg::COUNT_W'(agt_pkg::VERTEX_LIMIT);
    end else if (cfg_write_en) begin
      vertex_count <= cfg_write_data;
    end
  end

  // Symmetric edge update: each bit compares its own row and column.
  always_ff @(posedge clk) begin
    for (int r = 0; r < agt_pkg::VERTEX_LIMIT; r++) begin
      for (int c = 0; c < agt_pkg::VERTEX_LIMIT; c++) begin
        if (rst || ctrl.clear_rows) begin
          rows[r][c] <= 1'b0;
        end else if (ctrl.set_edge && edge_ok &&
                     (((agt_pkg::VIDX_W'(r) == in_data.vertex_a) &&
                       (agt_pkg::VIDX_W'(c) == in_data.vertex_b)) ||
                      ((agt_pkg::VIDX_W'(r) == in_data.vertex_b) &&
                       (agt_pkg::VIDX_W'(c) == in_data.vertex_a)))) begin
          rows[r][c] <= (in_data.weight != 8'd0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      head <= '0;
      tail <= '0;
      depth_first <= 1'b0;
      have_prev <= 1'b0;
    end else if (ctrl.start_walk) begin
      visited <= agt_pkg::VERTEX_LIMIT'(1) << in_data.vertex_a;
      head <= '0;
      tail <= agt_pkg::PTR_W'(1);
      depth_first <= (in_data.cmd == agt_pkg::OP_DFS);
      have_prev <= 1'b0;
    end else if (ctrl.pop) begin
      have_prev <= 1'b1;
      if (depth_first) begin
        tail <= tail - agt_pkg::PTR_W'(1);
      end else begin
        head <= head + agt_pkg::PTR_W'(1);
      end
    end else if (ctrl.push) begin
      visited <= visited | low_bit;
      if (tail < agt_pkg::PTR_W'(agt_pkg::VERTEX_LIMIT)) begin
        tail <= tail + agt_pkg::PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start_walk) begin
      pending[0] <= in_data.vertex_a;
    end else if (ctrl.push && (tail < agt_pkg::PTR_W'(agt_pkg::VERTEX_LIMIT))) begin
      pending[tail[agt_pkg::VIDX_W-1:0]] <= low_idx;
    end
    if (ctrl.pop) begin
      cur <= pop_vertex;
    end
  end

  // Hold each popped vertex until the next pop or the end of the walk settles its last flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit_bad || ctrl.emit_final || (ctrl.pop && have_prev)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_bad) begin
      out_data <= '{visited_vertex: '0, last_of_walk: 1'b1, bad_start: 1'b1};
    end else if (ctrl.emit_final) begin
      out_data <= '{visited_vertex: cur, last_of_walk: 1'b1, bad_start: 1'b0};
    end else if (ctrl.pop && have_prev) begin
      out_data <= '{visited_vertex: cur, last_of_walk: 1'b0, bad_start: 1'b0};
    end
  end

endmodule

@@ hdl/adjacency_matrix_graph_traversal.sv @@
// Top level of the adjacency-matrix graph traversal block: controller, datapath, checks.
//
// Clear and set-edge transactions are taken in IDLE and leave the controller there. A
// traversal whose start vertex is not below the vertex count passes through ERR and
// gives one error result, registered once the output register is free. A good traversal
// alternates POP and SCAN: the pending store moves at most one vertex per cycle, one pop
// or one push, a pop can wait on a stalled output, and each pop costs a row lookup. A
// finished result waits in the output register while the next transaction is taken.
module adjacency_matrix_graph_traversal (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  agt_pkg::agt_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output agt_pkg::agt_out_t           out_data,
  input  logic                        cfg_write_en,
  input  logic [agt_pkg::COUNT_W-1:0] cfg_write_data
);

  agt_pkg::agt_ctrl_t ctrl;
  agt_pkg::agt_stat_t stat;

  agt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  agt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_data        (in_data),
    .ctrl           (ctrl),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

`ifndef SYNTH
  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctrl))
    else $error("controller issued more than one command");

  a_walk_holds_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall &&
     ((in_data.cmd == agt_pkg::OP_BFS) || (in_data.cmd == agt_pkg::OP_DFS)))
    |=> in_stall)
    else $error("traversal transaction did not hold the input");

  a_final_has_vertex: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit_final |-> stat.have_prev)
    else $error("final result issued with no popped vertex");

  a_bad_start_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.bad_start) |->
    (out_data.last_of_walk && (out_data.visited_vertex == '0)))
    else $error("malformed error result");
`endif

endmodule
